// File: src/kwms_pkg.sv
package kwms_pkg;

   localparam int NUM_WAYS_DEF  = 8;
   localparam int WAY_DEPTH_DEF = 16;

   localparam int VALUE_W     = 32;
   localparam int WAY_FIELD_W = 3;
   localparam int CFG_W       = 4;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;
   localparam int REQ_USER_W  = 1;
   localparam int RSP_USER_W  = 2;

   localparam logic [CFG_W-1:0] ACTIVE_WAYS_RST = 4'd8;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef struct packed {
      logic load;
      logic push;
      logic rd;
      logic cmp;
      logic pop;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic req_pop;
      logic limit_zero;
      logic scan_last;
   } sts_type;

endpackage

// File: src/kwms_ram.sv
module kwms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/kwms_ctrl.sv
module kwms_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  kwms_pkg::sts_type sts,
   output kwms_pkg::cmd_type cmd
);
   import kwms_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PUSH = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_POP  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               priority if (!sts.req_pop) begin
                  state_in = S_PUSH;
               end else if (sts.limit_zero) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_DONE;
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = sts.scan_last ? S_POP : S_READ;
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_emit_from_done: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> state_ff == S_DONE)
      else $error("result loaded outside done state");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == S_IDLE && rsp_valid_ff)
      else $error("result load did not return to idle");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !cmd.load)
      else $error("request taken while busy");

endmodule

// File: src/kwms_dp.sv
module kwms_dp #(
   parameter int NUM_WAYS  = kwms_pkg::NUM_WAYS_DEF,
   parameter int WAY_DEPTH = kwms_pkg::WAY_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  kwms_pkg::cmd_type                cmd,
   output kwms_pkg::sts_type                sts,
   input  logic                             req_kind,
   input  logic [kwms_pkg::WAY_FIELD_W-1:0] req_way,
   input  logic [kwms_pkg::VALUE_W-1:0]     req_value,
   input  logic                             csr_valid,
   input  logic [kwms_pkg::CFG_W-1:0]       csr_data,
   output logic                             rsp_found,
   output logic [kwms_pkg::VALUE_W-1:0]     rsp_min_value,
   output logic [kwms_pkg::WAY_FIELD_W-1:0] rsp_source_way,
   output logic                             rsp_overflow
);
   import kwms_pkg::*;

   localparam int WAY_W  = $clog2(NUM_WAYS);
   localparam int LIM_W  = $clog2(NUM_WAYS + 1);
   localparam int IDX_W  = (WAY_DEPTH > 1) ? $clog2(WAY_DEPTH) : 1;
   localparam int FILL_W = $clog2(WAY_DEPTH + 1);
   localparam int MEM_D  = NUM_WAYS * (2 ** IDX_W);
   localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(WAY_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WAY_DEPTH);

   logic [CFG_W-1:0]   active_ways_ff;
   logic               is_pop_ff;
   logic [WAY_W-1:0]   push_way_ff;
   logic               push_bad_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [LIM_W-1:0]   scan_ff;
   logic               pend_ff;
   logic               have_ff;
   logic [VALUE_W-1:0] best_val_ff;
   logic [WAY_W-1:0]   best_way_ff;
   logic               ovf_ff;

   logic [IDX_W-1:0]  rd_idx_ff [NUM_WAYS];
   logic [IDX_W-1:0]  wr_idx_ff [NUM_WAYS];
   logic [FILL_W-1:0] fill_ff   [NUM_WAYS];

   logic               found_ff;
   logic [VALUE_W-1:0] min_value_ff;
   logic [WAY_FIELD_W-1:0] source_way_ff;
   logic               overflow_ff;

   logic [LIM_W-1:0]   limit;
   logic [WAY_W-1:0]   sel_way;
   logic [WAY_W-1:0]   scan_way;
   logic [IDX_W-1:0]   sel_rd_idx;
   logic [IDX_W-1:0]   sel_wr_idx;
   logic [FILL_W-1:0]  sel_fill;
   logic               sel_full;
   logic               sel_empty;
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [VALUE_W-1:0] ram_rd_data;
   logic               take;
   logic               found;

   assign limit = (int'(active_ways_ff) > NUM_WAYS) ? LIM_W'(NUM_WAYS)
                                                    : LIM_W'(active_ways_ff);
   assign scan_way = scan_ff[WAY_W-1:0];

   always_comb begin
      priority if (cmd.push) begin
         sel_way = push_way_ff;
      end else if (cmd.pop) begin
         sel_way = best_way_ff;
      end else begin
         sel_way = scan_way;
      end
   end

   assign sel_rd_idx = rd_idx_ff[sel_way];
   assign sel_wr_idx = wr_idx_ff[sel_way];
   assign sel_fill   = fill_ff[sel_way];
   assign sel_full   = (sel_fill == FILL_MAX);
   assign sel_empty  = (sel_fill == '0);

   assign ram_wr_en = cmd.push && !push_bad_ff && !sel_full;
   assign ram_rd_en = cmd.rd && !sel_empty;

   kwms_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(MEM_D)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr({sel_way, sel_wr_idx}),
      .wr_data(value_ff),
      .rd_en  (ram_rd_en),
      .rd_addr({sel_way, sel_rd_idx}),
      .rd_data(ram_rd_data)
   );

   assign take = cmd.cmp && pend_ff
                 && (!have_ff || ($signed(ram_rd_data) < $signed(best_val_ff)));

   assign sts.req_pop    = (req_kind == KIND_POP);
   assign sts.limit_zero = (limit == '0);
   assign sts.scan_last  = (scan_ff + LIM_W'(1) == limit);

   assign found = is_pop_ff && have_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ways_ff <= ACTIVE_WAYS_RST;
         have_ff        <= 1'b0;
         for (int i = 0; i < NUM_WAYS; i++) begin
            rd_idx_ff[i] <= '0;
            wr_idx_ff[i] <= '0;
            fill_ff[i]   <= '0;
         end
      end else begin
         if (csr_valid) begin
            active_ways_ff <= csr_data;
         end
         if (cmd.load) begin
            have_ff <= 1'b0;
         end else if (take) begin
            have_ff <= 1'b1;
         end
         if (ram_wr_en) begin
            wr_idx_ff[sel_way] <= (sel_wr_idx == IDX_LAST) ? '0 : sel_wr_idx + IDX_W'(1);
            fill_ff[sel_way]   <= sel_fill + FILL_W'(1);
         end
         if (cmd.pop && have_ff) begin
            rd_idx_ff[sel_way] <= (sel_rd_idx == IDX_LAST) ? '0 : sel_rd_idx + IDX_W'(1);
            fill_ff[sel_way]   <= sel_fill - FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_pop_ff   <= (req_kind == KIND_POP);
         push_way_ff <= WAY_W'(req_way);
         push_bad_ff <= (int'(req_way) >= NUM_WAYS);
         value_ff    <= req_value;
         scan_ff     <= '0;
         ovf_ff      <= 1'b0;
      end
      if (cmd.push) begin
         ovf_ff <= push_bad_ff || sel_full;
      end
      if (cmd.rd) begin
         pend_ff <= !sel_empty;
      end
      if (cmd.cmp) begin
         scan_ff <= scan_ff + LIM_W'(1);
      end
      if (take) begin
         best_val_ff <= ram_rd_data;
         best_way_ff <= scan_way;
      end
      if (cmd.emit) begin
         found_ff      <= found;
         min_value_ff  <= found ? best_val_ff : '0;
         source_way_ff <= found ? WAY_FIELD_W'(best_way_ff) : '0;
         overflow_ff   <= !is_pop_ff && ovf_ff;
      end
   end

   assign rsp_found      = found_ff;
   assign rsp_min_value  = min_value_ff;
   assign rsp_source_way = source_way_ff;
   assign rsp_overflow   = overflow_ff;

   a_rd_nonempty: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> sel_fill != '0 && cmd.rd)
      else $error("head read from an empty way");

   a_wr_not_full: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> fill_ff[$past(sel_way)] != '0)
      else $error("push did not raise fill count");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      sel_fill <= FILL_MAX || cmd.push)
      else $error("fill count above way depth");

endmodule

// File: src/kway_merge_selector_core.sv
// Channel | Direction | Handshake               | Payload
// req     | in        | req_tvalid / req_tready | tdata: way[2:0], value[34:3]; tuser: kind
// rsp     | out       | rsp_tvalid / rsp_tready | tdata: min_value[31:0], source_way[34:32];
//         |           |                         | tuser: found[0], overflow[1]
// csr     | in        | csr_valid / csr_ready   | csr_data: active_ways[3:0]
//
// Push: after the accepting edge the block moves through its push state to its done state.
// Pop: it scans L = min(active_ways, NUM_WAYS) ways, then pops the winner in its pop state;
// when L is zero it goes straight to done. Each way costs a read and a compare on the single
// read port of the way store. The result register loads in the done state.
// A new request is taken the cycle after the result register loads.
// Reset: synchronous, clears control state, way counters and sets active_ways to 8.
// A stalled result holds in the output register; the block waits in its done state
// until the register frees.
module kway_merge_selector_core #(
   parameter int NUM_WAYS  = kwms_pkg::NUM_WAYS_DEF,
   parameter int WAY_DEPTH = kwms_pkg::WAY_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kwms_pkg::REQ_DATA_W-1:0] req_tdata,  // way, value, zero pad
   input  logic [kwms_pkg::REQ_USER_W-1:0] req_tuser,  // kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [kwms_pkg::RSP_DATA_W-1:0] rsp_tdata,  // min_value, source_way, zero pad
   output logic [kwms_pkg::RSP_USER_W-1:0] rsp_tuser,  // found, overflow
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kwms_pkg::CFG_W-1:0]      csr_data
);
   import kwms_pkg::*;

   cmd_type                cmd;
   sts_type                sts;
   logic                   rsp_found;
   logic [VALUE_W-1:0]     rsp_min_value;
   logic [WAY_FIELD_W-1:0] rsp_source_way;
   logic                   rsp_overflow;

   assign csr_ready = 1'b1;

   kwms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kwms_dp #(
      .NUM_WAYS (NUM_WAYS),
      .WAY_DEPTH(WAY_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_kind      (req_tuser[0]),
      .req_way       (req_tdata[WAY_FIELD_W-1:0]),
      .req_value     (req_tdata[WAY_FIELD_W +: VALUE_W]),
      .csr_valid     (csr_valid && csr_ready),
      .csr_data      (csr_data),
      .rsp_found     (rsp_found),
      .rsp_min_value (rsp_min_value),
      .rsp_source_way(rsp_source_way),
      .rsp_overflow  (rsp_overflow)
   );

   assign rsp_tdata = {{(RSP_DATA_W - VALUE_W - WAY_FIELD_W){1'b0}},
                       rsp_source_way, rsp_min_value};
   assign rsp_tuser = {rsp_overflow, rsp_found};

endmodule
